// ----- rtl/core/esc_pkg.sv -----
// Shared types and constants of the environmental sensor compensation block.
// No dependencies.
`default_nettype none
package esc_pkg;

  // mode codes
  localparam logic [1:0] MODE_TEMP   = 2'd0;
  localparam logic [1:0] MODE_PRESS  = 2'd1;
  localparam logic [1:0] MODE_HUMID  = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_A    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_B    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LAST = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HUMID      = 3'd4;

  // formula constants
  localparam logic [63:0] PRESS_T_OFS  = 64'd128000;
  localparam logic [63:0] PRESS_RAW_FS = 64'd1048576;
  localparam logic [63:0] PRESS_SCALE  = 64'd3125;
  localparam logic [31:0] HUM_T_OFS    = 32'd76800;
  localparam logic [31:0] HUM_Y_OFS    = 32'd2097152;
  localparam logic [31:0] HUM_MAX      = 32'd419430400;

  typedef struct packed {
    logic [1:0]  mode;
    logic [19:0] raw_reading;
  } in_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] temperature_centi;
    logic [31:0]        pressure_q24_8;
    logic [16:0]        humidity_q22_10;
    logic               divisor_zero;
  } out_t;

  // datapath steps, one multiply each
  typedef enum logic [4:0] {
    ST_T0, ST_T1, ST_T2,
    ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7, ST_P8, ST_P9,
    ST_H0, ST_H1, ST_H2, ST_H3, ST_H4, ST_H5, ST_H6, ST_H7
  } step_t;

  typedef struct packed {
    logic  capture;
    step_t step;
    logic  mul_go;
    logic  div_go;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic div_zero;
  } status_t;

endpackage
`default_nettype wire

// ----- rtl/core/esc_mul.sv -----
// 64x64 multiplier keeping the low 64 product bits, three passes of one 32x32 unit.
// No dependencies.
`default_nettype none
module esc_mul (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        go,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic             done,
  output logic [63:0]      prod
);
  logic        busy_r, busy_nxt;
  logic [1:0]  ph_r, ph_nxt;
  logic        done_r, done_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [31:0] x, y;
  logic [63:0] pp;

  // partial product operand select
  always_comb begin
    unique case (ph_r)
      2'd1:    begin x = a[31:0];  y = b[63:32]; end
      2'd2:    begin x = a[63:32]; y = b[31:0];  end
      default: begin x = a[31:0];  y = b[31:0];  end
    endcase
    pp = 64'(x) * 64'(y);
  end

  // pass sequencing and accumulation
  always_comb begin
    busy_nxt = busy_r;
    ph_nxt   = ph_r;
    done_nxt = 1'b0;
    acc_nxt  = acc_r;
    if (go) begin
      busy_nxt = 1'b1;
      ph_nxt   = 2'd0;
    end else if (busy_r) begin
      if (ph_r == 2'd0) begin
        acc_nxt = pp;
      end else begin
        acc_nxt[63:32] = acc_r[63:32] + pp[31:0];
      end
      if (ph_r == 2'd2) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
      ph_nxt = ph_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ph_r   <= 2'd0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ph_r   <= ph_nxt;
      done_r <= done_nxt;
    end
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;
endmodule
`default_nettype wire

// ----- rtl/core/esc_div.sv -----
// 64-bit signed divider, truncating, one quotient bit per cycle.
// No dependencies; divisor must be nonzero.
`default_nettype none
module esc_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        go,
  input  wire logic [63:0] num,
  input  wire logic [63:0] den,
  output logic             done,
  output logic [63:0]      quo
);
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] q_r, q_nxt;
  logic [63:0] d_r, d_nxt;
  logic        neg_r, neg_nxt;
  logic [64:0] trial;
  logic [64:0] diff;

  // restoring step
  always_comb begin
    trial    = {rem_r, q_r[63]};
    diff     = trial - {1'b0, d_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    d_nxt    = d_r;
    neg_nxt  = neg_r;
    if (go) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd0;
      rem_nxt  = '0;
      q_nxt    = num[63] ? (64'd0 - num) : num;
      d_nxt    = den[63] ? (64'd0 - den) : den;
      neg_nxt  = num[63] ^ den[63];
    end else if (busy_r) begin
      if (!diff[64]) begin
        rem_nxt = diff[63:0];
        q_nxt   = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial[63:0];
        q_nxt   = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    d_r   <= d_nxt;
    neg_r <= neg_nxt;
  end

  assign done = done_r;
  assign quo  = neg_r ? (64'd0 - q_r) : q_r;
endmodule
`default_nettype wire

// ----- rtl/core/esc_datapath.sv -----
// Compensation datapath: coefficient registers, working registers, multiplier, divider.
// Depends on esc_pkg, esc_mul and esc_div.
`default_nettype none
module esc_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire esc_pkg::cmd_t                 cmd,
  output esc_pkg::status_t                   status,
  input  wire esc_pkg::in_t                  in_data,
  input  wire logic                          cfg_we,
  input  wire logic [esc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]                   cfg_data,
  output esc_pkg::out_t                      out_data
);
  import esc_pkg::*;

  function automatic logic [31:0] asr32(input logic [31:0] x, input logic [5:0] n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] x, input logic [5:0] n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic logic [63:0] sx16(input logic [15:0] x);
    return {{48{x[15]}}, x};
  endfunction

  logic [47:0] temp_r;
  logic [63:0] pa_r, pb_r, hum_r;
  logic [15:0] plast_r;
  logic [1:0]  mode_r;
  logic [19:0] raw_r;
  logic [31:0] ft_r, ft_nxt;
  logic [63:0] ra_r, ra_nxt, rb_r, rb_nxt, rc_r, rc_nxt, rd_r, rd_nxt;
  out_t        res_r, res_nxt;
  out_t        out_r;

  logic [63:0] mul_a, mul_b, prod, quo;
  logic        mul_done, div_done;

  // coefficient fields
  logic [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
  logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  always_comb begin
    t1 = {16'd0, temp_r[15:0]};
    t2 = {{16{temp_r[31]}}, temp_r[31:16]};
    t3 = {{16{temp_r[47]}}, temp_r[47:32]};
    p1 = {48'd0, pa_r[15:0]};
    p2 = sx16(pa_r[31:16]);
    p3 = sx16(pa_r[47:32]);
    p4 = sx16(pa_r[63:48]);
    p5 = sx16(pb_r[15:0]);
    p6 = sx16(pb_r[31:16]);
    p7 = sx16(pb_r[47:32]);
    p8 = sx16(pb_r[63:48]);
    p9 = sx16(plast_r);
    h1 = {24'd0, hum_r[7:0]};
    h2 = {{16{hum_r[23]}}, hum_r[23:8]};
    h3 = {24'd0, hum_r[31:24]};
    h4 = {{20{hum_r[43]}}, hum_r[43:32]};
    h5 = {{20{hum_r[55]}}, hum_r[55:44]};
    h6 = {{24{hum_r[63]}}, hum_r[63:56]};
  end

  // derived operands
  logic [63:0] v1p, s13, nump;
  logic [31:0] vh, dt, ds, sh;
  always_comb begin
    v1p  = {{32{ft_r[31]}}, ft_r} - PRESS_T_OFS;
    s13  = asr64(rc_r, 6'd13);
    nump = ((PRESS_RAW_FS - {44'd0, raw_r}) << 31) - rb_r;
    vh   = ft_r - HUM_T_OFS;
    dt   = {15'd0, raw_r[19:3]} - (t1 << 1);
    ds   = {16'd0, raw_r[19:4]} - t1;
    sh   = asr32(rc_r[31:0], 6'd15);
  end

  // multiplier operand select
  always_comb begin
    unique case (cmd.step)
      ST_T0: begin mul_a = {32'd0, dt};         mul_b = {32'd0, t2}; end
      ST_T1: begin mul_a = {32'd0, ds};         mul_b = {32'd0, ds}; end
      ST_T2: begin mul_a = {32'd0, rb_r[31:0]}; mul_b = {32'd0, t3}; end
      ST_P0: begin mul_a = v1p;                 mul_b = v1p; end
      ST_P1: begin mul_a = ra_r;                mul_b = p6; end
      ST_P2: begin mul_a = v1p;                 mul_b = p5; end
      ST_P3: begin mul_a = ra_r;                mul_b = p3; end
      ST_P4: begin mul_a = v1p;                 mul_b = p2; end
      ST_P5: begin mul_a = rc_r;                mul_b = p1; end
      ST_P6: begin mul_a = nump;                mul_b = PRESS_SCALE; end
      ST_P7: begin mul_a = p9;                  mul_b = s13; end
      ST_P8: begin mul_a = ra_r;                mul_b = s13; end
      ST_P9: begin mul_a = p8;                  mul_b = rc_r; end
      ST_H0: begin mul_a = {32'd0, h5};         mul_b = {32'd0, vh}; end
      ST_H1: begin mul_a = {32'd0, vh};         mul_b = {32'd0, h6}; end
      ST_H2: begin mul_a = {32'd0, vh};         mul_b = {32'd0, h3}; end
      ST_H3: begin mul_a = {32'd0, rb_r[31:0]}; mul_b = {32'd0, rc_r[31:0]}; end
      ST_H4: begin mul_a = {32'd0, rb_r[31:0]}; mul_b = {32'd0, h2}; end
      ST_H5: begin mul_a = {32'd0, ra_r[31:0]}; mul_b = {32'd0, rb_r[31:0]}; end
      ST_H6: begin mul_a = {32'd0, sh};         mul_b = {32'd0, sh}; end
      ST_H7: begin mul_a = {32'd0, rd_r[31:0]}; mul_b = {32'd0, h1}; end
      default: begin mul_a = '0;                mul_b = '0; end
    endcase
  end

  esc_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (cmd.mul_go),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  esc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (cmd.div_go),
    .num   (ra_r),
    .den   (rd_r),
    .done  (div_done),
    .quo   (quo)
  );

  // register updates on capture, after the divide and after each product
  logic [31:0] p32, ftn, hx, hv;
  logic [63:0] pfin;
  always_comb begin
    p32     = prod[31:0];
    ft_nxt  = ft_r;
    ra_nxt  = ra_r;
    rb_nxt  = rb_r;
    rc_nxt  = rc_r;
    rd_nxt  = rd_r;
    res_nxt = res_r;
    ftn     = ra_r[31:0] + asr32(p32, 6'd14);
    hx      = asr32(({12'd0, raw_r[15:0], 4'd0} << 10) - (h4 << 20) - p32 + 32'd16384,
                    6'd15);
    hv      = rc_r[31:0] - asr32(p32, 6'd4);
    pfin    = asr64(rc_r + rb_r + asr64(prod, 6'd19), 6'd8) + (p7 << 4);
    if (cmd.capture) begin
      res_nxt      = '0;
      res_nxt.kind = in_data.mode;
    end else if (div_done) begin
      rc_nxt = quo;
    end else if (mul_done) begin
      unique case (cmd.step)
        ST_T0: ra_nxt[31:0] = asr32(p32, 6'd11);
        ST_T1: rb_nxt[31:0] = asr32(p32, 6'd12);
        ST_T2: begin
          ft_nxt = ftn;
          res_nxt.temperature_centi =
            $signed(asr32((ftn << 2) + ftn + 32'd128, 6'd8));
        end
        ST_P0: ra_nxt = prod;
        ST_P1: rb_nxt = prod;
        ST_P2: rb_nxt = rb_r + (prod << 17) + (p4 << 35);
        ST_P3: rc_nxt = asr64(prod, 6'd8);
        ST_P4: rc_nxt = (64'd1 << 47) + rc_r + (prod << 12);
        ST_P5: begin
          rd_nxt = asr64(prod, 6'd33);
          res_nxt.divisor_zero = status.div_zero;
        end
        ST_P6: ra_nxt = prod;
        ST_P7: ra_nxt = prod;
        ST_P8: rb_nxt = asr64(prod, 6'd25);
        ST_P9: res_nxt.pressure_q24_8 = pfin[31:0];
        ST_H0: ra_nxt[31:0] = hx;
        ST_H1: rb_nxt[31:0] = asr32(p32, 6'd10);
        ST_H2: rc_nxt[31:0] = asr32(p32, 6'd11) + 32'd32768;
        ST_H3: rb_nxt[31:0] = asr32(p32, 6'd10) + HUM_Y_OFS;
        ST_H4: rb_nxt[31:0] = asr32(p32 + 32'd8192, 6'd14);
        ST_H5: rc_nxt[31:0] = p32;
        ST_H6: rd_nxt[31:0] = asr32(p32, 6'd7);
        ST_H7: begin
          priority if (hv[31]) begin
            res_nxt.humidity_q22_10 = '0;
          end else if (hv > HUM_MAX) begin
            res_nxt.humidity_q22_10 = HUM_MAX[28:12];
          end else begin
            res_nxt.humidity_q22_10 = hv[28:12];
          end
        end
        default: ;
      endcase
    end
  end

  // status toward the controller
  always_comb begin
    status.mul_done = mul_done;
    status.div_done = div_done;
    status.div_zero = (prod[63:33] == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_r  <= '0;
      pa_r    <= '0;
      pb_r    <= '0;
      plast_r <= '0;
      hum_r   <= '0;
      ft_r    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TEMP:       temp_r  <= cfg_data[47:0];
          CFG_PRESS_A:    pa_r    <= cfg_data;
          CFG_PRESS_B:    pb_r    <= cfg_data;
          CFG_PRESS_LAST: plast_r <= cfg_data[15:0];
          CFG_HUMID:      hum_r   <= cfg_data;
          default: ;
        endcase
      end
      ft_r <= ft_nxt;
    end
    if (cmd.capture) begin
      mode_r <= in_data.mode;
      raw_r  <= in_data.raw_reading;
    end
    ra_r  <= ra_nxt;
    rb_r  <= rb_nxt;
    rc_r  <= rc_nxt;
    rd_r  <= rd_nxt;
    res_r <= res_nxt;
    if (cmd.out_load) begin
      out_r <= res_r;
    end
  end

  assign out_data = out_r;

  // captured mode must match the result kind
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (res_r.kind == mode_r))
    else $error("result kind differs from captured mode");
endmodule
`default_nettype wire

// ----- rtl/core/esc_ctrl.sv -----
// Controller state machine sequencing datapath steps and the output handshake.
// Depends on esc_pkg.
`default_nettype none
module esc_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [1:0]       in_mode,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire esc_pkg::status_t status,
  output esc_pkg::cmd_t         cmd
);
  import esc_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_MWAIT, S_DIV, S_DWAIT, S_WRITE} state_t;

  state_t state_r;
  step_t  step_r;
  logic   out_valid_r;
  logic   accept;
  logic   load;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign load     = (state_r == S_WRITE) && (!out_valid_r || out_ready);

  // commands toward the datapath
  always_comb begin
    cmd.capture  = accept;
    cmd.step     = step_r;
    cmd.mul_go   = (state_r == S_MUL);
    cmd.div_go   = (state_r == S_DIV);
    cmd.out_load = load;
  end

  // state, step and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= ST_T0;
      out_valid_r <= 1'b0;
    end else begin
      priority if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            priority if (in_mode == MODE_TEMP) begin
              step_r  <= ST_T0;
              state_r <= S_MUL;
            end else if (in_mode == MODE_PRESS) begin
              step_r  <= ST_P0;
              state_r <= S_MUL;
            end else if (in_mode == MODE_HUMID) begin
              step_r  <= ST_H0;
              state_r <= S_MUL;
            end else begin
              state_r <= S_WRITE;
            end
          end
        end
        S_MUL: state_r <= S_MWAIT;
        S_MWAIT: begin
          if (status.mul_done) begin
            priority if (step_r == ST_T2 || step_r == ST_P9 || step_r == ST_H7) begin
              state_r <= S_WRITE;
            end else if (step_r == ST_P5 && status.div_zero) begin
              state_r <= S_WRITE;
            end else if (step_r == ST_P6) begin
              state_r <= S_DIV;
            end else begin
              step_r  <= step_t'(step_r + 5'd1);
              state_r <= S_MUL;
            end
          end
        end
        S_DIV: state_r <= S_DWAIT;
        S_DWAIT: begin
          if (status.div_done) begin
            step_r  <= ST_P7;
            state_r <= S_MUL;
          end
        end
        S_WRITE: begin
          if (load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;

  a_go_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.mul_go && cmd.div_go))
    else $error("multiplier and divider started together");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !cmd.out_load)
    else $error("pending result overwritten");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("request taken while previous still in work");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("loaded result not presented");
endmodule
`default_nettype wire

// ----- rtl/core/environmental_sensor_compensation_top.sv -----
// Pressure takes ten shared-multiplier passes plus a divide; a zero pressure
// divisor ends the sequence early without the divide. An unused mode goes
// straight to the result write.
// One request in work at a time; the shared 32x32 multiplier and the
// bit-serial divider set the rate. A finished result waits in an output
// register while the next request is taken. Synchronous active-low reset
// clears coefficients and fine temperature; no clearing pass.
// Top level; depends on esc_pkg, esc_ctrl and esc_datapath.
`default_nettype none
module environmental_sensor_compensation_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire esc_pkg::in_t                  in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output esc_pkg::out_t                      out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [esc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]                   cfg_data
);
  import esc_pkg::*;

  cmd_t    cmd;
  status_t status;

  // configuration is always taken
  assign cfg_ready = 1'b1;

  esc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_data.mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  esc_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );
endmodule
`default_nettype wire

// ----- tb/esc_checker.sv -----
// Checker for the environmental sensor compensation block: watches the
// config, request and result channels, predicts each result and compares.
// Depends on esc_pkg.
module esc_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  esc_pkg::in_t                  in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  esc_pkg::out_t                 out_data,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [esc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_data,
  output int                            fail_count,
  output int                            pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import esc_pkg::*;

  logic [47:0] temp_cf;
  logic [63:0] press_a_cf, press_b_cf, humid_cf;
  logic [15:0] press_last_cf;
  logic [31:0] t_fine;
  out_t        expected_results[$];

  assign pending_count = expected_results.size();

  function automatic logic [31:0] asr32(logic [31:0] x, int n);
    return $signed(x) >>> n;
  endfunction

  function automatic logic [63:0] asr64(logic [63:0] x, int n);
    return $signed(x) >>> n;
  endfunction

  function automatic logic [63:0] sext16(logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  // temperature, also updates the fine temperature
  function automatic logic [31:0] calc_temperature(logic [31:0] r);
    logic [31:0] t1, t2, t3, a, d, b;
    t1 = {16'd0, temp_cf[15:0]};
    t2 = {{16{temp_cf[31]}}, temp_cf[31:16]};
    t3 = {{16{temp_cf[47]}}, temp_cf[47:32]};
    a = asr32(((r >> 3) - (t1 << 1)) * t2, 11);
    d = (r >> 4) - t1;
    b = asr32(asr32(d * d, 12) * t3, 14);
    t_fine = a + b;
    return asr32(t_fine * 32'd5 + 32'd128, 8);
  endfunction

  function automatic logic [31:0] calc_pressure(logic [31:0] r, output logic zero);
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p, un, ud, q, num;
    p1 = {48'd0, press_a_cf[15:0]};
    p2 = sext16(press_a_cf[31:16]);
    p3 = sext16(press_a_cf[47:32]);
    p4 = sext16(press_a_cf[63:48]);
    p5 = sext16(press_b_cf[15:0]);
    p6 = sext16(press_b_cf[31:16]);
    p7 = sext16(press_b_cf[47:32]);
    p8 = sext16(press_b_cf[63:48]);
    p9 = sext16(press_last_cf);
    v1 = {{32{t_fine[31]}}, t_fine} - PRESS_T_OFS;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) << 17);
    v2 = v2 + (p4 << 35);
    v1 = asr64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
    v1 = asr64(((64'd1 << 47) + v1) * p1, 33);
    zero = (v1 == 64'd0);
    if (zero) return 32'd0;
    p = PRESS_RAW_FS - {32'd0, r};
    num = ((p << 31) - v2) * PRESS_SCALE;
    un = num[63] ? -num : num;
    ud = v1[63] ? -v1 : v1;
    q = un / ud;
    p = (num[63] != v1[63]) ? -q : q;
    v1 = asr64(p9 * asr64(p, 13) * asr64(p, 13), 25);
    v2 = asr64(p8 * p, 19);
    p = asr64(p + v1 + v2, 8) + (p7 << 4);
    return p[31:0];
  endfunction

  function automatic logic [16:0] calc_humidity(logic [31:0] r);
    logic [31:0] h1, h2, h3, h4, h5, h6, v, x, y, s;
    h1 = {24'd0, humid_cf[7:0]};
    h2 = {{16{humid_cf[23]}}, humid_cf[23:8]};
    h3 = {24'd0, humid_cf[31:24]};
    h4 = {{20{humid_cf[43]}}, humid_cf[43:32]};
    h5 = {{20{humid_cf[55]}}, humid_cf[55:44]};
    h6 = {{24{humid_cf[63]}}, humid_cf[63:56]};
    v = t_fine - HUM_T_OFS;
    x = asr32(({16'd0, r[15:0]} << 14) - (h4 << 20) - h5 * v + 32'd16384, 15);
    y = asr32(asr32(v * h6, 10) * (asr32(v * h3, 11) + 32'd32768), 10);
    y = asr32((y + HUM_Y_OFS) * h2 + 32'd8192, 14);
    v = x * y;
    s = asr32(v, 15);
    v = v - asr32(asr32(s * s, 7) * h1, 4);
    if (v[31]) v = 32'd0;
    else if (v > HUM_MAX) v = HUM_MAX;
    return v[28:12];
  endfunction

  function automatic out_t predict_result(in_t req);
    out_t res;
    logic z;
    res = '0;
    res.kind = req.mode;
    case (req.mode)
      MODE_TEMP:  res.temperature_centi = calc_temperature({12'd0, req.raw_reading});
      MODE_PRESS: begin
        res.pressure_q24_8 = calc_pressure({12'd0, req.raw_reading}, z);
        res.divisor_zero = z;
      end
      MODE_HUMID: res.humidity_q22_10 = calc_humidity({12'd0, req.raw_reading});
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // watch all channels at the rising edge
  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      temp_cf <= '0; press_a_cf <= '0; press_b_cf <= '0;
      press_last_cf <= '0; humid_cf <= '0; t_fine = '0;
      fail_count = 0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TEMP:       temp_cf <= cfg_data[47:0];
          CFG_PRESS_A:    press_a_cf <= cfg_data;
          CFG_PRESS_B:    press_b_cf <= cfg_data;
          CFG_PRESS_LAST: press_last_cf <= cfg_data[15:0];
          CFG_HUMID:      humid_cf <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_results.push_back(predict_result(in_data));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 64'(out_data.kind), 64'd0);
        end else begin
          want = expected_results.pop_front();
          if (out_data.kind !== want.kind)
            report_mismatch("kind", 64'(out_data.kind), 64'(want.kind));
          if (out_data.temperature_centi !== want.temperature_centi)
            report_mismatch("temperature", 64'(out_data.temperature_centi),
                            64'(want.temperature_centi));
          if (out_data.pressure_q24_8 !== want.pressure_q24_8)
            report_mismatch("pressure", 64'(out_data.pressure_q24_8),
                            64'(want.pressure_q24_8));
          if (out_data.humidity_q22_10 !== want.humidity_q22_10)
            report_mismatch("humidity", 64'(out_data.humidity_q22_10),
                            64'(want.humidity_q22_10));
          if (out_data.divisor_zero !== want.divisor_zero)
            report_mismatch("divisor zero", 64'(out_data.divisor_zero),
                            64'(want.divisor_zero));
        end
      end
    end
  end
endmodule

// ----- tb/tb_top.sv -----
// Stimulus and verdict for the environmental sensor compensation block.
// Depends on esc_pkg, esc_checker and the block's top level.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import esc_pkg::*;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  in_t  in_data;
  out_t out_data;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [63:0] cfg_data;
  int fail_count, pending_count;
  int cycle_count;
  bit long_hold;

  environmental_sensor_compensation_top DUT (.*);

  esc_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // cycle limit
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 2000000) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // result side with random stalls and one long hold-off
  initial begin
    int w;
    out_ready = 0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ready <= 0;
        repeat (1500) @(negedge clk);
        long_hold = 0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      out_ready <= 0;
      repeat (w) @(negedge clk);
      out_ready <= 1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic send_request(logic [1:0] md, logic [19:0] raw, bit burst);
    int w;
    w = burst ? 0 : $urandom_range(0, 8);
    repeat (w) @(negedge clk);
    @(negedge clk);
    in_valid <= 1; in_data <= '{mode: md, raw_reading: raw};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid <= 0;
  endtask

  task automatic drain();
    while (pending_count != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // typical factory calibration, randomized slightly
  task automatic load_typical();
    write_reg(CFG_TEMP, 64'({16'hFC18 + 16'($urandom_range(0, 16)), 16'd26435, 16'd27504}));
    write_reg(CFG_PRESS_A, {16'd2855, 16'hD0B5 ^ 16'($urandom_range(0, 7)), 16'hD67F,
                            16'd36477 + 16'($urandom_range(0, 99))});
    write_reg(CFG_PRESS_B, {16'hEF0F, 16'hC198, 16'hFFF9, 16'd140});
    write_reg(CFG_PRESS_LAST, 64'(16'd4000 + 16'($urandom_range(0, 999))));
    write_reg(CFG_HUMID, {8'd30, 12'd50, 12'd320, 8'd0, 16'd360, 8'd75});
  endtask

  function automatic logic [19:0] rand_raw();
    case ($urandom_range(0, 5))
      0: return 20'h00000;
      1: return 20'hFFFFF;
      default: return 20'($urandom);
    endcase
  endfunction

  initial begin
    logic [1:0] md;
    rst_n = 0; in_valid = 0; in_data = '0; cfg_valid = 0; cfg_index = '0;
    cfg_data = '0; long_hold = 0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n = 1;

    // all-zero coefficients: zero divisor, unused mode, humidity and temperature
    send_request(MODE_PRESS, 20'h80000, 0);
    send_request(MODE_HUMID, 20'hFFFFF, 0);
    send_request(MODE_UNUSED, 20'hFFFFF, 0);
    send_request(MODE_TEMP, 20'hFFFFF, 0);
    drain();

    // directed with typical calibration and field extremes
    load_typical();
    for (int i = 0; i < 4; i++) begin
      send_request(MODE_TEMP, 20'h80000 >> (i * 5), 0);
    end
    send_request(MODE_TEMP, 20'd519888, 0);
    send_request(MODE_PRESS, 20'd415148, 0);
    send_request(MODE_PRESS, 20'h00000, 0);
    send_request(MODE_PRESS, 20'hFFFFF, 0);
    send_request(MODE_HUMID, 20'd30000, 0);
    send_request(MODE_HUMID, 20'h0FFFF, 0);
    send_request(MODE_HUMID, 20'h00000, 0);
    send_request(MODE_UNUSED, 20'h5A5A5, 0);
    send_request(MODE_TEMP, 20'h00000, 0);
    send_request(MODE_PRESS, 20'hAAAAA, 0);
    send_request(MODE_HUMID, 20'h55555, 0);
    drain();

    // extreme coefficient settings
    write_reg(CFG_TEMP, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_PRESS_A, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_PRESS_B, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_PRESS_LAST, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_HUMID, 64'hFFFF_FFFF_FFFF_FFFF);
    for (int k = 0; k < 3; k++) begin
      send_request(MODE_TEMP, rand_raw(), 0);
      send_request(MODE_PRESS, rand_raw(), 0);
      send_request(MODE_HUMID, rand_raw(), 0);
    end
    drain();

    // random phases: mostly realistic calibration, some random coefficients
    for (int ph = 0; ph < 10; ph++) begin
      if (ph % 3 == 2) begin
        write_reg(CFG_TEMP, rand64());
        write_reg(CFG_PRESS_A, rand64());
        write_reg(CFG_PRESS_B, rand64());
        write_reg(CFG_PRESS_LAST, rand64());
        write_reg(CFG_HUMID, rand64());
      end else begin
        load_typical();
      end
      if (ph == 4) long_hold = 1;
      for (int n = 0; n < 200; n++) begin
        md = ($urandom_range(0, 19) == 0) ? MODE_UNUSED : 2'($urandom_range(0, 2));
        send_request(md, (md == MODE_TEMP && ph % 3 != 2 && $urandom_range(0, 1)) ?
                     20'd400000 + 20'($urandom_range(0, 200000)) : rand_raw(),
                     ph == 4 && n < 40);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/core/esc_pkg.sv
rtl/core/esc_mul.sv
rtl/core/esc_div.sv
rtl/core/esc_datapath.sv
rtl/core/esc_ctrl.sv
rtl/core/environmental_sensor_compensation_top.sv
tb/esc_checker.sv
tb/tb_top.sv
